FILE: rtl/core/imt_pkg.sv
// ----------------------------------------------------------------------------
// imt_pkg
// Shared types and constants of the iterative mean threshold block.
// ----------------------------------------------------------------------------
package imt_pkg;

  localparam int unsigned MaxPixelsLog2 = 20;
  localparam int unsigned MaxIterations = 64;

  localparam int unsigned HistW  = MaxPixelsLog2 + 1;
  localparam int unsigned CountW = HistW + 8;
  localparam int unsigned SumW   = HistW + 16;
  localparam int unsigned IterW  = $clog2(MaxIterations + 1);

  localparam logic [7:0] InitThrReset = 8'd200;
  localparam logic [7:0] TolReset     = 8'd5;

  typedef enum logic [1:0] {
    StClassified = 2'd0,
    StConverged  = 2'd1,
    StEmpty      = 2'd2,
    StIterLimit  = 2'd3
  } status_e;

  typedef enum logic {
    CmdAccumulate = 1'b0,
    CmdClassify   = 1'b1
  } command_e;

  typedef enum logic [7:0] {
    FsmIdle   = 8'b0000_0001,
    FsmDrain  = 8'b0000_0010,
    FsmSweep  = 8'b0000_0100,
    FsmCheck  = 8'b0000_1000,
    FsmDivide = 8'b0001_0000,
    FsmUpdate = 8'b0010_0000,
    FsmResult = 8'b0100_0000,
    FsmClear  = 8'b1000_0000
  } fsm_e;

endpackage

FILE: rtl/core/iterative_mean_threshold.sv
// ----------------------------------------------------------------------------
// iterative_mean_threshold
// Histogram based isodata threshold selection and pixel binarization.
// ----------------------------------------------------------------------------
// Accumulate beats (tuser 0) are counted into a 256 x 21 bit histogram RAM
// at one beat per cycle while the block is idle and its output register is
// free; a read-modify-write pipeline with one-deep forwarding covers repeated
// gray levels. The beat with tlast set starts the isodata iteration: each
// iteration sweeps all 256 bins through the RAM read port, then divides the
// two class sums by their counts in a shared 16-step restoring divider; a
// frame end runs at most MaxIterations iterations. The result beat then goes
// out and the RAM is cleared, during which no beat is accepted; the same
// clearing pass runs after reset. Classify beats (tuser 1) are answered in
// the cycle after acceptance with 255 or 0.
module iterative_mean_threshold (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // pixel
  input  logic        s_axis_tuser,   // command
  input  logic        s_axis_tlast,   // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // out_pixel, threshold
  output logic [1:0]  m_axis_tuser,   // status
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned HW = imt_pkg::HistW;
  localparam int unsigned CW = imt_pkg::CountW;
  localparam int unsigned SW = imt_pkg::SumW;
  localparam int unsigned IW = imt_pkg::IterW;

  imt_pkg::fsm_e state_q, state_d;

  logic [7:0] init_thr_q, tol_q;
  logic [15:0] cur_thr_q, t_q;

  logic [HW-1:0] hist_mem [256];
  logic [HW-1:0] rdata_q;

  // config port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = {24'd0, paddr[2] ? tol_q : init_thr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_thr_q <= imt_pkg::InitThrReset;
      tol_q      <= imt_pkg::TolReset;
    end else if (cfg_wr) begin
      if (paddr[2]) tol_q <= pwdata[7:0];
      else          init_thr_q <= pwdata[7:0];
    end
  end

  // output register
  logic        out_free;
  logic        out_valid_q;
  logic [23:0] out_data_q;
  logic [1:0]  out_user_q;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  logic in_acc;
  assign s_axis_tready = (state_q == imt_pkg::FsmIdle) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  logic is_classify;
  assign is_classify = (s_axis_tuser == imt_pkg::CmdClassify);

  // accumulate pipeline
  logic          acc_v_q;
  logic [7:0]    acc_addr_q;
  logic          wr_v_q;
  logic [7:0]    wr_addr_q;
  logic [HW-1:0] wr_data_q;
  logic [HW-1:0] acc_base, acc_new;

  assign acc_base = (wr_v_q && wr_addr_q == acc_addr_q) ? wr_data_q : rdata_q;
  assign acc_new  = acc_base[HW-1] ? acc_base : acc_base + HW'(1);

  // sweep and accumulators
  logic [8:0]    sw_cnt_q;
  logic          sw_v_q;
  logic [7:0]    sw_bin_q;
  logic [CW-1:0] c_hi_q, c_lo_q;
  logic [SW-1:0] s_hi_q, s_lo_q;
  logic [SW-1:0] prod;
  logic          in_hi;
  assign prod  = SW'(rdata_q * sw_bin_q);
  assign in_hi = {sw_bin_q, 8'd0} >= t_q;

  // divider
  logic          div_lo_q;
  logic [4:0]    div_cnt_q;
  logic [CW:0]   rem_q;
  logic [15:0]   dsh_q, quo_q, m_hi_q;
  logic [CW:0]   trial;
  logic [CW-1:0] divisor;
  assign divisor = div_lo_q ? c_lo_q : c_hi_q;
  assign trial   = {rem_q[CW-1:0], dsh_q[15]};

  // update
  logic [16:0] mean_sum;
  logic [15:0] nt, diff;
  logic [IW-1:0] iter_q;
  assign mean_sum = {1'b0, m_hi_q} + {1'b0, quo_q};
  assign nt       = mean_sum[16:1];
  assign diff     = (nt > t_q) ? nt - t_q : t_q - nt;

  logic [1:0] res_status_q;
  logic [8:0] clr_cnt_q;

  // memory ports
  logic          mem_we;
  logic [7:0]    mem_waddr;
  logic [HW-1:0] mem_wdata;
  logic [7:0]    mem_raddr;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = acc_addr_q;
    mem_wdata = acc_new;
    if (state_q == imt_pkg::FsmClear) begin
      mem_we    = !clr_cnt_q[8];
      mem_waddr = clr_cnt_q[7:0];
      mem_wdata = '0;
    end else if (acc_v_q) begin
      mem_we = 1'b1;
    end
    mem_raddr = (state_q == imt_pkg::FsmSweep) ? sw_cnt_q[7:0] : s_axis_tdata;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) hist_mem[mem_waddr] <= mem_wdata;
    rdata_q <= hist_mem[mem_raddr];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      imt_pkg::FsmIdle:
        if (in_acc && !is_classify && s_axis_tlast) state_d = imt_pkg::FsmDrain;
      imt_pkg::FsmDrain:  state_d = imt_pkg::FsmSweep;
      imt_pkg::FsmSweep:
        if (sw_cnt_q[8] && !sw_v_q) state_d = imt_pkg::FsmCheck;
      imt_pkg::FsmCheck:
        state_d = (c_hi_q == '0 || c_lo_q == '0) ? imt_pkg::FsmResult
                                                 : imt_pkg::FsmDivide;
      imt_pkg::FsmDivide:
        if (div_cnt_q == 5'd16 && div_lo_q) state_d = imt_pkg::FsmUpdate;
      imt_pkg::FsmUpdate:
        state_d = (diff <= {tol_q, 8'd0} ||
                   iter_q == IW'(imt_pkg::MaxIterations - 1))
                  ? imt_pkg::FsmResult : imt_pkg::FsmSweep;
      imt_pkg::FsmResult:
        if (out_free) state_d = imt_pkg::FsmClear;
      imt_pkg::FsmClear:
        if (clr_cnt_q[8]) state_d = imt_pkg::FsmIdle;
      default: state_d = imt_pkg::FsmClear;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= imt_pkg::FsmClear;
      out_valid_q  <= 1'b0;
      acc_v_q      <= 1'b0;
      wr_v_q       <= 1'b0;
      sw_v_q       <= 1'b0;
      sw_cnt_q     <= '0;
      clr_cnt_q    <= '0;
      div_cnt_q    <= '0;
      div_lo_q     <= 1'b0;
      iter_q       <= '0;
      cur_thr_q    <= {imt_pkg::InitThrReset, 8'd0};
    end else begin
      state_q <= state_d;
      if (m_axis_tready) out_valid_q <= 1'b0;

      acc_v_q <= in_acc && !is_classify;
      wr_v_q  <= acc_v_q;

      if (state_q == imt_pkg::FsmClear) clr_cnt_q <= clr_cnt_q + 9'd1;
      else clr_cnt_q <= '0;

      sw_v_q <= (state_q == imt_pkg::FsmSweep) && !sw_cnt_q[8];
      if (state_q == imt_pkg::FsmSweep && !sw_cnt_q[8]) sw_cnt_q <= sw_cnt_q + 9'd1;
      else if (state_q != imt_pkg::FsmSweep) sw_cnt_q <= '0;

      case (state_q)
        imt_pkg::FsmIdle: begin
          iter_q <= '0;
          if (in_acc && is_classify) out_valid_q <= 1'b1;
        end
        imt_pkg::FsmCheck: begin
          div_cnt_q <= '0;
          div_lo_q  <= 1'b0;
          if (c_hi_q == '0 || c_lo_q == '0) cur_thr_q <= t_q;
        end
        imt_pkg::FsmDivide: begin
          if (div_cnt_q == 5'd16) begin
            div_cnt_q <= '0;
            div_lo_q  <= 1'b1;
          end else begin
            div_cnt_q <= div_cnt_q + 5'd1;
          end
        end
        imt_pkg::FsmUpdate: begin
          iter_q    <= iter_q + IW'(1);
          cur_thr_q <= nt;
        end
        imt_pkg::FsmResult: begin
          if (out_free) out_valid_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) acc_addr_q <= s_axis_tdata;
    wr_addr_q <= acc_addr_q;
    wr_data_q <= acc_new;
    sw_bin_q  <= sw_cnt_q[7:0];

    if (state_q == imt_pkg::FsmIdle && in_acc && is_classify) begin
      out_data_q <= {cur_thr_q,
                     ({s_axis_tdata, 8'd0} >= cur_thr_q) ? 8'd255 : 8'd0};
      out_user_q <= imt_pkg::StClassified;
    end
    if (state_q == imt_pkg::FsmResult && out_free) begin
      out_data_q <= {cur_thr_q, 8'd0};
      out_user_q <= res_status_q;
    end

    if (state_q == imt_pkg::FsmDrain) t_q <= {init_thr_q, 8'd0};
    if (state_q == imt_pkg::FsmUpdate) t_q <= nt;

    if (state_q == imt_pkg::FsmDrain || state_q == imt_pkg::FsmUpdate) begin
      c_hi_q <= '0;
      c_lo_q <= '0;
      s_hi_q <= '0;
      s_lo_q <= '0;
    end else if (sw_v_q) begin
      if (in_hi) begin
        c_hi_q <= c_hi_q + CW'(rdata_q);
        s_hi_q <= s_hi_q + prod;
      end else begin
        c_lo_q <= c_lo_q + CW'(rdata_q);
        s_lo_q <= s_lo_q + prod;
      end
    end

    if (state_q == imt_pkg::FsmCheck)
      res_status_q <= imt_pkg::StEmpty;
    if (state_q == imt_pkg::FsmUpdate)
      res_status_q <= (diff <= {tol_q, 8'd0}) ? imt_pkg::StConverged
                                             : imt_pkg::StIterLimit;

    if (state_q == imt_pkg::FsmCheck ||
        (state_q == imt_pkg::FsmDivide && div_cnt_q == 5'd16 && !div_lo_q)) begin
      if (state_q == imt_pkg::FsmCheck) begin
        rem_q <= {1'b0, s_hi_q[SW-1:8]};
        dsh_q <= {s_hi_q[7:0], 8'd0};
      end else begin
        rem_q  <= {1'b0, s_lo_q[SW-1:8]};
        dsh_q  <= {s_lo_q[7:0], 8'd0};
        m_hi_q <= quo_q;
      end
      quo_q <= '0;
    end else if (state_q == imt_pkg::FsmDivide && div_cnt_q != 5'd16) begin
      dsh_q <= {dsh_q[14:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_q <= trial - {1'b0, divisor};
        quo_q <= {quo_q[14:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[14:0], 1'b0};
      end
    end
  end

endmodule
